### rtl/core/mer_pkg.sv
// Package for the midpoint ellipse rasterizer: widths, codes, command and status types.
// Shared by mer_ctrl, mer_dpath and midpoint_ellipse_rasterizer_unit; depends on nothing.
package mer_pkg;

  // Field widths
  localparam int RADIUS_BITS = 10;
  localparam int COORD_BITS  = 11;
  localparam int OUT_BITS    = COORD_BITS + 2;
  localparam int SLOPE_BITS  = 32;
  localparam int DEC_BITS    = 44;
  localparam int SQ_BITS     = 2 * RADIUS_BITS;

  // Shared multiplier: widest use is ry^2 * (2x+1) on the A side
  localparam int TX_BITS    = RADIUS_BITS + 1;
  localparam int MUL_A_BITS = SQ_BITS + TX_BITS;
  localparam int MUL_B_BITS = SQ_BITS;
  localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

  // Stream widths
  localparam int IN_FIELD_BITS  = 2 * COORD_BITS + 2 * RADIUS_BITS;
  localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((4 * OUT_BITS + 7) / 8) * 8;
  localparam int OUT_TUSER_BITS = 3;

  // Action codes carried in the input tuser
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // Region codes of the result
  localparam logic [1:0] REGION_NONE = 2'd0;
  localparam logic [1:0] REGION_ONE  = 2'd1;
  localparam logic [1:0] REGION_TWO  = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_START_RXSQ,
    ST_START_RYSQ,
    ST_START_PROD,
    ST_START_P1,
    ST_START_EMIT,
    ST_SW_TXA,
    ST_SW_TXB,
    ST_SW_YMA,
    ST_SW_YMB,
    ST_SW_RR,
    ST_SW_SUB,
    ST_SW_ROUND,
    ST_MOVE,
    ST_DEC,
    ST_ZERO
  } state_e;

  typedef enum logic [2:0] {
    MA_RX,
    MA_RY,
    MA_RX_SQ,
    MA_RY_SQ,
    MA_PROD
  } mul_a_e;

  typedef enum logic [2:0] {
    MB_RX,
    MB_RY,
    MB_TX,
    MB_YM,
    MB_RY_SQ
  } mul_b_e;

  typedef enum logic [1:0] {
    MD_NONE,
    MD_RX_SQ,
    MD_RY_SQ,
    MD_PROD
  } mul_dst_e;

  typedef enum logic [2:0] {
    ACC_NONE,
    ACC_INIT_P1,
    ACC_LOAD_PROD,
    ACC_ADD4,
    ACC_SUB4
  } acc_op_e;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_POINT,
    EMIT_ZERO
  } emit_e;

  typedef struct packed {
    logic     ld_in;
    mul_a_e   mul_a;
    mul_b_e   mul_b;
    mul_dst_e mul_dst;
    acc_op_e  acc_op;
    logic     dec_round;
    logic     step_move;
    logic     dec_update;
    emit_e    emit;
  } dp_cmd_t;

  typedef struct packed {
    logic active;
    logic switch_needed;
    logic out_free;
  } dp_sts_t;

endpackage

### rtl/core/mer_ctrl.sv
// Sequencer of the ellipse rasterizer: input handshake and the command schedule.
// Depends on mer_pkg; drives mer_dpath through dp_cmd_t and reads dp_sts_t.
module mer_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  input  logic            action_i,
  output logic            s_tready_o,
  input  mer_pkg::dp_sts_t sts_i,
  output mer_pkg::dp_cmd_t cmd_o
);
  import mer_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and command
  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    cmd_o.mul_a    = MA_RX;
    cmd_o.mul_b    = MB_RX;
    cmd_o.mul_dst  = MD_NONE;
    cmd_o.acc_op   = ACC_NONE;
    cmd_o.emit     = EMIT_NONE;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (action_i == ACT_START) begin
            cmd_o.ld_in = 1'b1;
            state_d     = ST_START_RXSQ;
          end else if (!sts_i.active) begin
            state_d = ST_ZERO;
          end else if (sts_i.switch_needed) begin
            state_d = ST_SW_TXA;
          end else begin
            cmd_o.step_move = 1'b1;
            state_d         = ST_DEC;
          end
        end
      end
      ST_START_RXSQ: begin
        cmd_o.mul_a   = MA_RX;
        cmd_o.mul_b   = MB_RX;
        cmd_o.mul_dst = MD_RX_SQ;
        state_d       = ST_START_RYSQ;
      end
      ST_START_RYSQ: begin
        cmd_o.mul_a   = MA_RY;
        cmd_o.mul_b   = MB_RY;
        cmd_o.mul_dst = MD_RY_SQ;
        state_d       = ST_START_PROD;
      end
      ST_START_PROD: begin
        cmd_o.mul_a   = MA_RX_SQ;
        cmd_o.mul_b   = MB_RY;
        cmd_o.mul_dst = MD_PROD;
        state_d       = ST_START_P1;
      end
      ST_START_P1: begin
        cmd_o.acc_op = ACC_INIT_P1;
        state_d      = ST_START_EMIT;
      end
      ST_START_EMIT: begin
        // Hold until the output register can take the first point
        if (sts_i.out_free) begin
          cmd_o.dec_round = 1'b1;
          cmd_o.emit      = EMIT_POINT;
          state_d         = ST_IDLE;
        end
      end
      ST_SW_TXA: begin
        cmd_o.mul_a   = MA_RY_SQ;
        cmd_o.mul_b   = MB_TX;
        cmd_o.mul_dst = MD_PROD;
        state_d       = ST_SW_TXB;
      end
      ST_SW_TXB: begin
        cmd_o.mul_a   = MA_PROD;
        cmd_o.mul_b   = MB_TX;
        cmd_o.mul_dst = MD_PROD;
        state_d       = ST_SW_YMA;
      end
      ST_SW_YMA: begin
        cmd_o.acc_op  = ACC_LOAD_PROD;
        cmd_o.mul_a   = MA_RX_SQ;
        cmd_o.mul_b   = MB_YM;
        cmd_o.mul_dst = MD_PROD;
        state_d       = ST_SW_YMB;
      end
      ST_SW_YMB: begin
        cmd_o.mul_a   = MA_PROD;
        cmd_o.mul_b   = MB_YM;
        cmd_o.mul_dst = MD_PROD;
        state_d       = ST_SW_RR;
      end
      ST_SW_RR: begin
        cmd_o.acc_op  = ACC_ADD4;
        cmd_o.mul_a   = MA_RX_SQ;
        cmd_o.mul_b   = MB_RY_SQ;
        cmd_o.mul_dst = MD_PROD;
        state_d       = ST_SW_SUB;
      end
      ST_SW_SUB: begin
        cmd_o.acc_op = ACC_SUB4;
        state_d      = ST_SW_ROUND;
      end
      ST_SW_ROUND: begin
        cmd_o.dec_round = 1'b1;
        state_d         = ST_MOVE;
      end
      ST_MOVE: begin
        cmd_o.step_move = 1'b1;
        state_d         = ST_DEC;
      end
      ST_DEC: begin
        if (sts_i.out_free) begin
          cmd_o.dec_update = 1'b1;
          cmd_o.emit       = EMIT_POINT;
          state_d          = ST_IDLE;
        end
      end
      ST_ZERO: begin
        if (sts_i.out_free) begin
          cmd_o.emit = EMIT_ZERO;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // A result is only written into a free output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit != EMIT_NONE) |-> sts_i.out_free)
    else $error("emit while output register busy");

  // An accepted transaction always leaves the idle state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("accepted transaction not started");

  // The region switch sequence only begins on an active quadrant
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SW_TXA) |-> $past(sts_i.active && sts_i.switch_needed))
    else $error("region switch without cause");

endmodule

### rtl/core/mer_dpath.sv
// Datapath of the ellipse rasterizer: held item, shared multiplier, slope terms,
// decision value and the output register. Depends on mer_pkg; commanded by mer_ctrl.
module mer_dpath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [mer_pkg::IN_TDATA_BITS-1:0]    s_tdata_i,
  input  mer_pkg::dp_cmd_t                      cmd_i,
  output mer_pkg::dp_sts_t                      sts_o,
  input  logic                                 m_tready_i,
  output logic                                 m_tvalid_o,
  output logic [mer_pkg::OUT_TDATA_BITS-1:0]   m_tdata_o,
  output logic [mer_pkg::OUT_TUSER_BITS-1:0]   m_tuser_o,
  output logic                                 m_tlast_o
);
  import mer_pkg::*;

  localparam int CY_LO = COORD_BITS;
  localparam int RX_LO = 2 * COORD_BITS;
  localparam int RY_LO = 2 * COORD_BITS + RADIUS_BITS;

  logic [COORD_BITS-1:0]  cx_q, cy_q;
  logic [RADIUS_BITS-1:0] rx_q;
  logic [RADIUS_BITS-1:0] ox_q, oy_q;
  logic [SQ_BITS-1:0]     rx_sq_q, ry_sq_q;
  logic [SLOPE_BITS-1:0]  sx_q, sy_q;
  logic [DEC_BITS-1:0]    dec_q, acc_q;
  logic [PROD_BITS-1:0]   prod_q;
  logic                   in_r2_q, active_q;
  logic                   mvx_q, mvy_q;

  logic [MUL_A_BITS-1:0]  mul_a;
  logic [MUL_B_BITS-1:0]  mul_b;
  logic [PROD_BITS-1:0]   mul_p;
  logic [TX_BITS-1:0]     tx;
  logic [RADIUS_BITS-1:0] ym;
  logic [DEC_BITS-1:0]    quad_prod;
  logic [DEC_BITS:0]      rnd_sum;
  logic [DEC_BITS-1:0]    rnd_val;
  logic [DEC_BITS-1:0]    delta;
  logic                   dec_neg, dec_pos;
  logic                   move_x, move_y;

  logic                       out_valid_q;
  logic [OUT_TDATA_BITS-1:0]  out_data_q;
  logic [OUT_TUSER_BITS-1:0]  out_user_q;
  logic                       out_last_q;
  logic [OUT_BITS-1:0]        x_plus, x_minus, y_plus, y_minus;

  // Operands of the switch-point decision value
  assign tx = {ox_q, 1'b1};
  assign ym = (oy_q == '0) ? '0 : oy_q - 1'b1;

  // Shared multiplier operand selection
  always_comb begin
    case (cmd_i.mul_a)
      MA_RX:    mul_a = MUL_A_BITS'(rx_q);
      MA_RY:    mul_a = MUL_A_BITS'(oy_q);
      MA_RX_SQ: mul_a = MUL_A_BITS'(rx_sq_q);
      MA_RY_SQ: mul_a = MUL_A_BITS'(ry_sq_q);
      MA_PROD:  mul_a = prod_q[MUL_A_BITS-1:0];
      default:  mul_a = '0;
    endcase
    case (cmd_i.mul_b)
      MB_RX:    mul_b = MUL_B_BITS'(rx_q);
      MB_RY:    mul_b = MUL_B_BITS'(oy_q);
      MB_TX:    mul_b = MUL_B_BITS'(tx);
      MB_YM:    mul_b = MUL_B_BITS'(ym);
      MB_RY_SQ: mul_b = ry_sq_q;
      default:  mul_b = '0;
    endcase
  end

  assign mul_p = PROD_BITS'(mul_a) * PROD_BITS'(mul_b);

  // Rounded quarter of the accumulator, half away from zero
  assign quad_prod = {prod_q[DEC_BITS-3:0], 2'b00};
  assign rnd_sum   = {acc_q[DEC_BITS-1], acc_q}
                   + (acc_q[DEC_BITS-1] ? (DEC_BITS+1)'(1) : (DEC_BITS+1)'(2));
  assign rnd_val   = {rnd_sum[DEC_BITS], rnd_sum[DEC_BITS:2]};

  // Midpoint move choice
  assign dec_neg = dec_q[DEC_BITS-1];
  assign dec_pos = !dec_neg && (dec_q != '0);
  assign move_x  = in_r2_q ? !dec_pos : 1'b1;
  assign move_y  = in_r2_q ? 1'b1 : !dec_neg;

  // Decision increment from the updated slope terms
  assign delta = (in_r2_q ? DEC_BITS'(rx_sq_q) : DEC_BITS'(ry_sq_q))
               + (mvx_q ? DEC_BITS'(sx_q) : '0)
               - (mvy_q ? DEC_BITS'(sy_q) : '0);

  // Working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_in) begin
      cx_q <= s_tdata_i[CY_LO-1:0];
      cy_q <= s_tdata_i[RX_LO-1:CY_LO];
      rx_q <= s_tdata_i[RY_LO-1:RX_LO];
      oy_q <= s_tdata_i[RY_LO+RADIUS_BITS-1:RY_LO];
      ox_q <= '0;
      sx_q <= '0;
    end
    case (cmd_i.mul_dst)
      MD_RX_SQ: rx_sq_q <= mul_p[SQ_BITS-1:0];
      MD_RY_SQ: ry_sq_q <= mul_p[SQ_BITS-1:0];
      MD_PROD:  prod_q  <= mul_p;
      default:  ;
    endcase
    case (cmd_i.acc_op)
      ACC_INIT_P1: begin
        acc_q <= DEC_BITS'({ry_sq_q, 2'b00}) - quad_prod + DEC_BITS'(rx_sq_q);
        sy_q  <= SLOPE_BITS'({prod_q, 1'b0});
      end
      ACC_LOAD_PROD: acc_q <= prod_q[DEC_BITS-1:0];
      ACC_ADD4:      acc_q <= acc_q + quad_prod;
      ACC_SUB4:      acc_q <= acc_q - quad_prod;
      default:       ;
    endcase
    // Advance the offsets and slope terms
    if (cmd_i.step_move) begin
      mvx_q <= move_x;
      mvy_q <= move_y;
      if (move_x) begin
        if (ox_q != '1) ox_q <= ox_q + 1'b1;
        sx_q <= sx_q + SLOPE_BITS'({ry_sq_q, 1'b0});
      end
      if (move_y) begin
        if (oy_q != '0) oy_q <= oy_q - 1'b1;
        sy_q <= sy_q - SLOPE_BITS'({rx_sq_q, 1'b0});
      end
    end
    if (cmd_i.dec_round) begin
      dec_q <= rnd_val;
    end else if (cmd_i.dec_update) begin
      dec_q <= dec_q + delta;
    end
  end

  // Region and activity flags; only the switch rounding (no point written) enters region two
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_r2_q  <= 1'b0;
      active_q <= 1'b0;
    end else begin
      if (cmd_i.ld_in) begin
        in_r2_q <= 1'b0;
      end else if (cmd_i.dec_round && (cmd_i.emit == EMIT_NONE) && active_q) begin
        in_r2_q <= 1'b1;
      end
      if (cmd_i.emit == EMIT_POINT) begin
        active_q <= (oy_q != '0);
      end
    end
  end

  // Mirrored coordinates
  assign x_plus  = OUT_BITS'(cx_q) + OUT_BITS'(ox_q);
  assign x_minus = OUT_BITS'(cx_q) - OUT_BITS'(ox_q);
  assign y_plus  = OUT_BITS'(cy_q) + OUT_BITS'(oy_q);
  assign y_minus = OUT_BITS'(cy_q) - OUT_BITS'(oy_q);

  // Output register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit != EMIT_NONE) begin
      out_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.emit)
      EMIT_POINT: begin
        out_data_q <= OUT_TDATA_BITS'({y_minus, y_plus, x_minus, x_plus});
        out_user_q <= {1'b1, (in_r2_q ? REGION_TWO : REGION_ONE)};
        out_last_q <= (oy_q == '0);
      end
      EMIT_ZERO: begin
        out_data_q <= '0;
        out_user_q <= {1'b0, REGION_NONE};
        out_last_q <= 1'b0;
      end
      default: ;
    endcase
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_data_q;
  assign m_tuser_o  = out_user_q;
  assign m_tlast_o  = out_last_q;

  assign sts_o.active        = active_q;
  assign sts_o.switch_needed = active_q && !in_r2_q && !(sx_q < sy_q);
  assign sts_o.out_free      = !out_valid_q || m_tready_i;

  // Offsets only move while a quadrant is being drawn
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step_move |-> active_q)
    else $error("offset step while idle");

  // A point with zero vertical offset closes the quadrant
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_i.emit == EMIT_POINT) && (oy_q == '0)) |=> !active_q)
    else $error("quadrant not closed on last point");

  // Region two is entered once per quadrant
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.dec_round && (cmd_i.emit == EMIT_NONE)) |-> !in_r2_q)
    else $error("second region switch");

endmodule

### rtl/core/midpoint_ellipse_rasterizer_unit.sv
// Top level of the midpoint ellipse rasterizer: stream ports around sequencer and datapath.
// Depends on mer_pkg, mer_ctrl and mer_dpath.
//
//  channel  | direction | tdata (low bit up)                        | tuser / tlast
//  ---------+-----------+-------------------------------------------+---------------------------
//  s_axis   | in        | center_x, center_y, radius_x, radius_y    | tuser: action
//  m_axis   | out       | x_plus, x_minus, y_plus, y_minus          | tuser: region, point_valid;
//           |           |                                           | tlast: last
//
// Ordinary step: accept, then decision update and output write.
// Start and the step that enters region two run through a sequence of states that
// use the one shared 31 x 20 multiplier in turn for the squares and products.
// Step while idle or finished: accept, then a zero result. One transaction is in work at a time.
// The output register holds a result until taken; a stalled output delays only the
// final state of the next transaction. Reset clears the sequencer and flags at once.
module midpoint_ellipse_rasterizer_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [mer_pkg::IN_TDATA_BITS-1:0]   s_axis_tdata,  // center_x, center_y, radius_x, radius_y, pad
  input  logic                                s_axis_tuser,  // action
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [mer_pkg::OUT_TDATA_BITS-1:0]  m_axis_tdata,  // x_plus, x_minus, y_plus, y_minus, pad
  output logic [mer_pkg::OUT_TUSER_BITS-1:0]  m_axis_tuser,  // region[1:0], point_valid
  output logic                                m_axis_tlast
);
  import mer_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mer_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .action_i   (s_axis_tuser),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mer_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tdata_i  (s_axis_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast)
  );

endmodule
